[rtl/mbps_pkg.sv]
`default_nettype none

package mbps_pkg;

  // configuration port
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_VALUE_LOW  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VALUE_HIGH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MASK_LOW   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MASK_HIGH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LENGTH     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE       = 3'd5;

  // pattern storage holds 16 bytes, length field is 5 bits
  localparam int PAT_LIMIT = 16;
  localparam int LEN_W     = 5;
  localparam int MODE_W    = 2;
  localparam int OUT_OFF_W = 32;

  localparam logic [MODE_W-1:0] MODE_FIRST_FWD = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LAST      = 2'd1;
  localparam logic [MODE_W-1:0] MODE_ALL_FWD   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_ALL_BWD   = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_HIT_OUT,
    S_END,
    S_DRAIN_RD,
    S_DRAIN_OUT,
    S_DONE_OUT
  } state_t;

  typedef struct packed {
    logic shift_in;
    logic eval;
    logic load_hit;
    logic rd_issue;
    logic load_drain;
    logic load_done;
    logic clear_run;
  } cmd_t;

  typedef struct packed {
    logic emit_hit;
    logic last;
    logic drain_mode;
    logic fill_nonzero;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

[rtl/mbps_in_if.sv]
`default_nettype none

interface mbps_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source(output valid, output data_byte, output last_byte, input ready);
  modport sink(input valid, input data_byte, input last_byte, output ready);
endinterface

`default_nettype wire

[rtl/mbps_out_if.sv]
`default_nettype none

interface mbps_out_if;
  logic        valid;
  logic        ready;
  logic        match_found;
  logic [31:0] match_offset;
  logic        scan_done;
  logic        stack_overflow;

  modport source(output valid, output match_found, output match_offset,
                 output scan_done, output stack_overflow, input ready);
  modport sink(input valid, input match_found, input match_offset,
               input scan_done, input stack_overflow, output ready);
endinterface

`default_nettype wire

[rtl/mbps_ctrl.sv]
`default_nettype none

module mbps_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  mbps_pkg::status_t status,
  output mbps_pkg::cmd_t    cmd
);
  import mbps_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.shift_in = 1'b1;
          state_next   = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.eval = 1'b1;
        if (status.emit_hit) begin
          state_next = S_HIT_OUT;
        end else if (status.last) begin
          state_next = S_END;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_HIT_OUT: begin
        if (status.out_free) begin
          cmd.load_hit = 1'b1;
          state_next   = status.last ? S_END : S_IDLE;
        end
      end
      S_END: begin
        if (status.drain_mode && status.fill_nonzero) begin
          state_next = S_DRAIN_RD;
        end else begin
          state_next = S_DONE_OUT;
        end
      end
      S_DRAIN_RD: begin
        cmd.rd_issue = 1'b1;
        state_next   = S_DRAIN_OUT;
      end
      S_DRAIN_OUT: begin
        if (status.out_free) begin
          cmd.load_drain = 1'b1;
          state_next     = status.fill_nonzero ? S_DRAIN_RD : S_DONE_OUT;
        end
      end
      S_DONE_OUT: begin
        if (status.out_free) begin
          cmd.load_done = 1'b1;
          cmd.clear_run = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  a_one_load: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load_hit, cmd.load_drain, cmd.load_done}))
    else $error("more than one result load in a cycle");

  a_read_then_out: assert property (@(posedge clk) disable iff (rst)
    cmd.rd_issue |=> state == S_DRAIN_OUT)
    else $error("stack read not followed by drain output");

  a_shift_then_eval: assert property (@(posedge clk) disable iff (rst)
    cmd.shift_in |=> cmd.eval)
    else $error("accepted byte not evaluated");

endmodule

`default_nettype wire

[rtl/mbps_datapath.sv]
`default_nettype none

module mbps_datapath #(
  parameter int PATTERN_MAX = 16,
  parameter int MATCH_DEPTH = 32,
  parameter int OFFSET_BITS = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [mbps_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mbps_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic [7:0]                       data_byte,
  input  logic                             last_byte,
  input  mbps_pkg::cmd_t                   cmd,
  output mbps_pkg::status_t                status,
  input  logic                             out_ready,
  output logic                             out_valid,
  output logic                             match_found,
  output logic [mbps_pkg::OUT_OFF_W-1:0]   match_offset,
  output logic                             scan_done,
  output logic                             stack_overflow
);
  import mbps_pkg::*;

  localparam int N_CMP = (PATTERN_MAX < PAT_LIMIT) ? PATTERN_MAX : PAT_LIMIT;
  localparam int IW    = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int VW    = $clog2(PATTERN_MAX + 1);
  localparam int CW    = (VW > LEN_W) ? VW : LEN_W;
  localparam int PW    = (MATCH_DEPTH > 1) ? $clog2(MATCH_DEPTH) : 1;
  localparam int FW    = $clog2(MATCH_DEPTH + 1);

  // configuration registers
  logic [PAT_LIMIT*8-1:0] pat_value;
  logic [PAT_LIMIT*8-1:0] pat_mask;
  logic [LEN_W-1:0]       pat_len;
  logic [MODE_W-1:0]      mode;

  // scan state
  logic [7:0]             window [PATTERN_MAX];
  logic [VW-1:0]          win_valid;
  logic [OFFSET_BITS-1:0] byte_count;
  logic                   last_q;
  logic                   first_seen;
  logic [OFFSET_BITS-1:0] latest_offset;
  logic [OFFSET_BITS-1:0] start_q;
  logic [OFFSET_BITS-1:0] offset_stack [MATCH_DEPTH];
  logic [OFFSET_BITS-1:0] rd_data;
  logic [PW-1:0]          stack_pos;
  logic [FW-1:0]          stack_fill;
  logic                   overflow_flag;

  logic [LEN_W-1:0]       eff_len;
  logic [CW-1:0]          idx_full;
  logic [IW-1:0]          idx;
  logic                   hit;
  logic [OFFSET_BITS-1:0] start;
  logic [PW-1:0]          pos_inc;
  logic [PW-1:0]          pos_dec;
  logic                   out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      pat_value <= '0;
      pat_mask  <= '0;
      pat_len   <= '0;
      mode      <= MODE_FIRST_FWD;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_VALUE_LOW:  pat_value[CFG_DATA_W-1:0]            <= cfg_data;
        CFG_VALUE_HIGH: pat_value[2*CFG_DATA_W-1:CFG_DATA_W] <= cfg_data;
        CFG_MASK_LOW:   pat_mask[CFG_DATA_W-1:0]             <= cfg_data;
        CFG_MASK_HIGH:  pat_mask[2*CFG_DATA_W-1:CFG_DATA_W]  <= cfg_data;
        CFG_LENGTH:     pat_len <= cfg_data[LEN_W-1:0];
        CFG_MODE:       mode    <= cfg_data[MODE_W-1:0];
        default: ;
      endcase
    end
  end

  assign eff_len = (pat_len > LEN_W'(N_CMP)) ? LEN_W'(N_CMP) : pat_len;

  // pattern byte i lines up with window entry len-1-i, newest byte at entry 0
  always_comb begin
    idx_full = '0;
    idx      = '0;
    hit      = (eff_len != '0) && (CW'(win_valid) >= CW'(eff_len));
    for (int i = 0; i < N_CMP; i++) begin
      idx_full = CW'(eff_len) - CW'(i) - CW'(1);
      idx      = idx_full[IW-1:0];
      if (LEN_W'(i) < eff_len) begin
        if (((window[idx] ^ pat_value[8*i +: 8]) & pat_mask[8*i +: 8]) != 8'd0) begin
          hit = 1'b0;
        end
      end
    end
  end

  assign start   = byte_count - OFFSET_BITS'(eff_len);
  assign pos_inc = (stack_pos == PW'(MATCH_DEPTH - 1)) ? '0 : stack_pos + PW'(1);
  assign pos_dec = (stack_pos == '0) ? PW'(MATCH_DEPTH - 1) : stack_pos - PW'(1);

  always_ff @(posedge clk) begin
    if (cmd.shift_in) begin
      window[0] <= data_byte;
      for (int i = 1; i < PATTERN_MAX; i++) begin
        window[i] <= window[i-1];
      end
    end
    if (cmd.eval) begin
      start_q <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win_valid     <= '0;
      byte_count    <= '0;
      last_q        <= 1'b0;
      first_seen    <= 1'b0;
      latest_offset <= '0;
      stack_pos     <= '0;
      stack_fill    <= '0;
      overflow_flag <= 1'b0;
    end else begin
      if (cmd.shift_in) begin
        byte_count <= byte_count + OFFSET_BITS'(1);
        last_q     <= last_byte;
        if (win_valid != VW'(PATTERN_MAX)) begin
          win_valid <= win_valid + VW'(1);
        end
      end
      if (cmd.eval && hit) begin
        first_seen    <= 1'b1;
        latest_offset <= start;
        stack_pos     <= pos_inc;
        if (stack_fill != FW'(MATCH_DEPTH)) begin
          stack_fill <= stack_fill + FW'(1);
        end else begin
          overflow_flag <= 1'b1;
        end
      end
      if (cmd.rd_issue) begin
        stack_pos  <= pos_dec;
        stack_fill <= stack_fill - FW'(1);
      end
      if (cmd.clear_run) begin
        win_valid     <= '0;
        byte_count    <= '0;
        first_seen    <= 1'b0;
        latest_offset <= '0;
        stack_pos     <= '0;
        stack_fill    <= '0;
        overflow_flag <= 1'b0;
      end
    end
  end

  // offset stack, one write and one registered read port
  always_ff @(posedge clk) begin
    if (cmd.eval && hit) begin
      offset_stack[stack_pos] <= start;
    end
    if (cmd.rd_issue) begin
      rd_data <= offset_stack[pos_dec];
    end
  end

  // result register
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_hit || cmd.load_drain || cmd.load_done) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_hit) begin
      match_found    <= 1'b1;
      match_offset   <= OUT_OFF_W'(start_q);
      scan_done      <= 1'b0;
      stack_overflow <= 1'b0;
    end else if (cmd.load_drain) begin
      match_found    <= 1'b1;
      match_offset   <= OUT_OFF_W'(rd_data);
      scan_done      <= 1'b0;
      stack_overflow <= overflow_flag;
    end else if (cmd.load_done) begin
      match_found    <= (mode == MODE_LAST) && first_seen;
      match_offset   <= (mode == MODE_LAST) ? OUT_OFF_W'(latest_offset) : '0;
      scan_done      <= 1'b1;
      stack_overflow <= (mode == MODE_ALL_BWD) && overflow_flag;
    end
  end

  always_comb begin
    status.emit_hit     = hit && ((mode == MODE_ALL_FWD) ||
                                  ((mode == MODE_FIRST_FWD) && !first_seen));
    status.last         = last_q;
    status.drain_mode   = (mode == MODE_ALL_BWD);
    status.fill_nonzero = (stack_fill != '0);
    status.out_free     = out_free;
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    stack_fill <= FW'(MATCH_DEPTH))
    else $error("stack fill beyond depth");

  a_overflow_set: assert property (@(posedge clk) disable iff (rst)
    (cmd.eval && hit && (stack_fill == FW'(MATCH_DEPTH))) |=> overflow_flag)
    else $error("match on full stack did not flag overflow");

  a_done_shown: assert property (@(posedge clk) disable iff (rst)
    cmd.load_done |=> (out_valid && scan_done))
    else $error("done result not presented");

endmodule

`default_nettype wire

[rtl/masked_byte_pattern_scanner.sv]
`default_nettype none

// channel       | direction | payload
// --------------+-----------+------------------------------------------------
// byte_stream   | in        | data_byte[7:0], last_byte
// result        | out       | match_found, match_offset[31:0], scan_done,
//               |           | stack_overflow
// cfg_*         | in        | write enable, register index[2:0], data[63:0]
//
// a byte that gives no result goes through transfer, then window compare
// a hit result adds a load that waits while the single result register is full
// the last byte adds an end step plus the done transfer; in all-backward mode each
// stacked offset adds a registered stack read, then a result load
// reset is synchronous; no clearing pass, stack entries are read only once written
// a stalled result stalls the sequencer only when a new result must be loaded

module masked_byte_pattern_scanner #(
  parameter int PATTERN_MAX = 16,
  parameter int MATCH_DEPTH = 32,
  parameter int OFFSET_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [mbps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mbps_pkg::CFG_DATA_W-1:0] cfg_data,
  mbps_in_if.sink                         byte_stream,
  mbps_out_if.source                      result
);
  import mbps_pkg::*;

  // commands from the sequencer, status back from the datapath
  cmd_t    cmd;
  status_t status;
  logic    in_ready;

  assign byte_stream.ready = in_ready;

  // sequencer: accept, evaluate, report hit, drain stack, report done
  mbps_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (byte_stream.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // datapath: config registers, byte window and comparators, offset stack,
  // result register
  mbps_datapath #(
    .PATTERN_MAX (PATTERN_MAX),
    .MATCH_DEPTH (MATCH_DEPTH),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .data_byte      (byte_stream.data_byte),
    .last_byte      (byte_stream.last_byte),
    .cmd            (cmd),
    .status         (status),
    .out_ready      (result.ready),
    .out_valid      (result.valid),
    .match_found    (result.match_found),
    .match_offset   (result.match_offset),
    .scan_done      (result.scan_done),
    .stack_overflow (result.stack_overflow)
  );

endmodule

`default_nettype wire

[verif/masked_byte_pattern_scanner_test.sv]
`default_nettype none

module masked_byte_pattern_scanner_test;
  import mbps_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int STACK_DEPTH   = 32;
  localparam int SETTLE_CYCLES = 6;      // pause after the done transfer before new settings
  localparam int END_CYCLES    = 24;
  localparam int HOLD_CYCLES   = 120;    // long receiver hold-off
  localparam int RANDOM_ITEMS  = 40;
  localparam int CYCLE_LIMIT   = 1_500_000;

  // one result of the scanner, in port order
  typedef struct packed {
    logic        found;
    logic [31:0] offset;
    logic        done;
    logic        ovf;
  } scan_result_t;

  typedef enum logic [1:0] {
    ROW_WRITE,        // register write, sent only while the block is idle; the block does not enforce it
    ROW_BYTE,         // byte, results come from the predictor
    ROW_BYTE_KNOWN    // byte with its single result typed in the row
  } row_kind_t;

  typedef struct packed {
    row_kind_t              kind;
    logic [CFG_IDX_W-1:0]   reg_idx;
    logic [CFG_DATA_W-1:0]  reg_val;
    logic [7:0]             data;
    logic                   last;
    scan_result_t           want;
  } stim_row_t;

  localparam scan_result_t NO_RESULT  = '0;
  localparam scan_result_t DONE_PLAIN = '{1'b0, 32'd0, 1'b1, 1'b0};

  // directed part: reset defaults, exact and nibble-masked patterns, every mode,
  // length beyond the window and a region shorter than the pattern
  localparam int DIRECTED_ROWS = 36;
  localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
    // reset config: length zero never matches, first-forward done only
    '{ROW_BYTE_KNOWN, '0, '0, 8'h00, 1'b1, DONE_PLAIN},
    '{ROW_BYTE,       '0, '0, 8'hFF, 1'b0, NO_RESULT},
    '{ROW_BYTE_KNOWN, '0, '0, 8'hA5, 1'b1, DONE_PLAIN},
    // two-byte exact pattern 55 aa
    '{ROW_WRITE, CFG_VALUE_LOW, 64'h0000_0000_0000_AA55, '0, '0, NO_RESULT},
    '{ROW_WRITE, CFG_MASK_LOW,  64'h0000_0000_0000_FFFF, '0, '0, NO_RESULT},
    '{ROW_WRITE, CFG_LENGTH,    64'd2,                   '0, '0, NO_RESULT},
    // first forward: only the first hit is reported
    '{ROW_BYTE,       '0, '0, 8'h55, 1'b0, NO_RESULT},
    '{ROW_BYTE_KNOWN, '0, '0, 8'hAA, 1'b0, '{1'b1, 32'd0, 1'b0, 1'b0}},
    '{ROW_BYTE,       '0, '0, 8'h55, 1'b0, NO_RESULT},
    '{ROW_BYTE,       '0, '0, 8'hAA, 1'b0, NO_RESULT},
    '{ROW_BYTE_KNOWN, '0, '0, 8'h00, 1'b1, DONE_PLAIN},
    // last match: hit completes on the last byte, reported with done
    '{ROW_WRITE, CFG_MODE, 64'(MODE_LAST), '0, '0, NO_RESULT},
    '{ROW_BYTE,       '0, '0, 8'h55, 1'b0, NO_RESULT},
    '{ROW_BYTE,       '0, '0, 8'hAA, 1'b0, NO_RESULT},
    '{ROW_BYTE,       '0, '0, 8'h55, 1'b0, NO_RESULT},
    '{ROW_BYTE_KNOWN, '0, '0, 8'hAA, 1'b1, '{1'b1, 32'd2, 1'b1, 1'b0}},
    // all backward: offsets drained in descending order
    '{ROW_WRITE, CFG_MODE, 64'(MODE_ALL_BWD), '0, '0, NO_RESULT},
    '{ROW_BYTE, '0, '0, 8'h55, 1'b0, NO_RESULT},
    '{ROW_BYTE, '0, '0, 8'hAA, 1'b0, NO_RESULT},
    '{ROW_BYTE, '0, '0, 8'h55, 1'b0, NO_RESULT},
    '{ROW_BYTE, '0, '0, 8'hAA, 1'b1, NO_RESULT},
    // all forward with only the upper nibble of byte 1 compared
    '{ROW_WRITE, CFG_MODE,     64'(MODE_ALL_FWD),       '0, '0, NO_RESULT},
    '{ROW_WRITE, CFG_MASK_LOW, 64'h0000_0000_0000_F0FF, '0, '0, NO_RESULT},
    '{ROW_BYTE, '0, '0, 8'h55, 1'b0, NO_RESULT},
    '{ROW_BYTE, '0, '0, 8'hA3, 1'b0, NO_RESULT},
    '{ROW_BYTE, '0, '0, 8'h55, 1'b0, NO_RESULT},
    '{ROW_BYTE, '0, '0, 8'h5A, 1'b0, NO_RESULT},
    '{ROW_BYTE, '0, '0, 8'h55, 1'b1, NO_RESULT},
    // oversized length saturates at the full window; region too short to match
    '{ROW_WRITE, CFG_VALUE_LOW,  64'h0000_0000_0000_0000, '0, '0, NO_RESULT},
    '{ROW_WRITE, CFG_MASK_LOW,   64'h8000_0000_0000_0001, '0, '0, NO_RESULT},
    '{ROW_WRITE, CFG_VALUE_HIGH, 64'hFFFF_FFFF_FFFF_FFFF, '0, '0, NO_RESULT},
    '{ROW_WRITE, CFG_MASK_HIGH,  64'hFFFF_FFFF_FFFF_FFFF, '0, '0, NO_RESULT},
    '{ROW_WRITE, CFG_LENGTH,     64'd31,                  '0, '0, NO_RESULT},
    '{ROW_BYTE,       '0, '0, 8'hFF, 1'b0, NO_RESULT},
    '{ROW_BYTE,       '0, '0, 8'h00, 1'b0, NO_RESULT},
    '{ROW_BYTE_KNOWN, '0, '0, 8'h7E, 1'b1, DONE_PLAIN}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  mbps_in_if  byte_ch ();
  mbps_out_if result_ch ();

  masked_byte_pattern_scanner u_top (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .byte_stream (byte_ch),
    .result      (result_ch)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // shadow copy of the registers
  logic [63:0] reg_value_lo = '0;
  logic [63:0] reg_value_hi = '0;
  logic [63:0] reg_mask_lo  = '0;
  logic [63:0] reg_mask_hi  = '0;
  logic [LEN_W-1:0]  reg_length = '0;
  logic [MODE_W-1:0] reg_mode   = MODE_FIRST_FWD;

  // scan state of the predictor
  logic [7:0]  scan_window [PAT_LIMIT];
  logic [31:0] scan_count;
  int          window_fill;
  bit          seen_hit;
  logic [31:0] newest_hit;
  logic [31:0] hit_stack [STACK_DEPTH];
  int          stack_wr;
  int          stack_count;
  bit          stack_dropped;

  scan_result_t step_results [$];     // results caused by the byte just taken
  scan_result_t expected_results [$]; // results still owed by the block

  int  errors        = 0;
  int  random_items  = 0;
  int  cycle_count   = 0;
  bit  quiet         = 1'b0;   // no gaps on either side while set
  bit  hold_req      = 1'b0;   // asks the receiver for a long hold-off

  // pattern bytes in use, capped at the window size
  function automatic int pattern_span();
    return (reg_length > PAT_LIMIT) ? PAT_LIMIT : int'(reg_length);
  endfunction

  // mostly no gap, some short gaps, a few long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  function automatic logic [63:0] pick_word();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // per-byte mix of fully compared, wildcard and partial masks
  function automatic logic [63:0] pick_mask();
    logic [63:0] m;
    int k;
    m = '0;
    if ($urandom_range(0, 7) == 0) return m;
    for (k = 0; k < 8; k++) begin
      case ($urandom_range(0, 3))
        0: m[8*k +: 8] = 8'h00;
        1: m[8*k +: 8] = 8'hFF;
        default: m[8*k +: 8] = 8'($urandom);
      endcase
    end
    return m;
  endfunction

  function automatic logic [63:0] pick_length();
    case ($urandom_range(0, 9))
      0: return 64'd0;
      1: return 64'd16;
      2: return 64'($urandom_range(17, 31));
      default: return 64'($urandom_range(1, 6));
    endcase
  endfunction

  task automatic clear_scan();
    int i;
    for (i = 0; i < PAT_LIMIT; i++) scan_window[i] = 8'h00;
    scan_count    = '0;
    window_fill   = 0;
    seen_hit      = 1'b0;
    newest_hit    = '0;
    stack_wr      = 0;
    stack_count   = 0;
    stack_dropped = 1'b0;
  endtask

  // shift one byte into the window and work out the results it causes
  task automatic scan_byte(logic [7:0] data, logic last);
    int len;
    int i;
    int idx;
    bit hit;
    logic [31:0]  start;
    logic [127:0] pat_value;
    logic [127:0] pat_mask;
    step_results.delete();
    len = pattern_span();
    pat_value = {reg_value_hi, reg_value_lo};
    pat_mask  = {reg_mask_hi, reg_mask_lo};
    for (i = PAT_LIMIT - 1; i > 0; i--) scan_window[i] = scan_window[i-1];
    scan_window[0] = data;
    scan_count = scan_count + 32'd1;
    if (window_fill < PAT_LIMIT) window_fill++;

    // pattern byte 0 lines up with the oldest byte of the span
    hit = 1'b0;
    start = '0;
    if (len > 0 && window_fill >= len) begin
      hit = 1'b1;
      for (i = 0; i < len; i++) begin
        if (((scan_window[len-1-i] ^ pat_value[8*i +: 8]) & pat_mask[8*i +: 8]) != 8'h00)
          hit = 1'b0;
      end
      start = scan_count - 32'(len);
    end

    if (hit) begin
      if ((reg_mode == MODE_FIRST_FWD && !seen_hit) || reg_mode == MODE_ALL_FWD)
        step_results.push_back(scan_result_t'{1'b1, start, 1'b0, 1'b0});
      seen_hit   = 1'b1;
      newest_hit = start;
      // ring keeps the highest offsets, oldest one is overwritten when full
      hit_stack[stack_wr] = start;
      stack_wr = (stack_wr + 1) % STACK_DEPTH;
      if (stack_count < STACK_DEPTH) stack_count++;
      else stack_dropped = 1'b1;
    end

    if (last) begin
      case (reg_mode)
        MODE_ALL_BWD: begin
          idx = stack_wr;
          repeat (stack_count) begin
            idx = (idx + STACK_DEPTH - 1) % STACK_DEPTH;
            step_results.push_back(scan_result_t'{1'b1, hit_stack[idx], 1'b0, stack_dropped});
          end
          step_results.push_back(scan_result_t'{1'b0, 32'd0, 1'b1, stack_dropped});
        end
        MODE_LAST: begin
          step_results.push_back(
            scan_result_t'{seen_hit, seen_hit ? newest_hit : 32'd0, 1'b1, 1'b0});
        end
        default: begin
          step_results.push_back(DONE_PLAIN);
        end
      endcase
      clear_scan();
    end
  endtask

  // register write, one clock with the enable high
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_VALUE_LOW:  reg_value_lo = value;
      CFG_VALUE_HIGH: reg_value_hi = value;
      CFG_MASK_LOW:   reg_mask_lo  = value;
      CFG_MASK_HIGH:  reg_mask_hi  = value;
      CFG_LENGTH:     reg_length   = value[LEN_W-1:0];
      CFG_MODE:       reg_mode     = value[MODE_W-1:0];
      default: ;
    endcase
  endtask

  // offer one byte and hold it until the transfer; valid stays high afterwards
  task automatic send_byte(logic [7:0] data, logic last, bit known, scan_result_t want);
    byte_ch.valid     <= 1'b1;
    byte_ch.data_byte <= data;
    byte_ch.last_byte <= last;
    do @(posedge clk); while (!byte_ch.ready);
    scan_byte(data, last);
    if (known) expected_results.push_back(want);
    else foreach (step_results[k]) expected_results.push_back(step_results[k]);
  endtask

  task automatic sender_gap(int n);
    if (n > 0) begin
      byte_ch.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // stop offering, wait for every owed result, then let the block settle
  task automatic quiesce(int extra);
    byte_ch.valid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
    repeat (extra) @(posedge clk);
  endtask

  // one region; with plant set, pattern copies with random wildcard bits are mixed in
  task automatic run_region(int rlen, bit plant, int pause_at);
    logic [7:0]   region_bytes [$];
    logic [127:0] pat_value;
    logic [127:0] pat_mask;
    logic [7:0]   pm;
    int len;
    int k;
    len = pattern_span();
    pat_value = {reg_value_hi, reg_value_lo};
    pat_mask  = {reg_mask_hi, reg_mask_lo};
    while (region_bytes.size() < rlen) begin
      if (plant && len > 0 && region_bytes.size() + len <= rlen &&
          $urandom_range(0, 2) == 0) begin
        for (k = 0; k < len; k++) begin
          pm = pat_mask[8*k +: 8];
          region_bytes.push_back((pat_value[8*k +: 8] & pm) | (8'($urandom) & ~pm));
        end
      end else begin
        region_bytes.push_back(8'($urandom));
      end
    end
    for (k = 0; k < rlen; k++) begin
      send_byte(region_bytes[k], k == rlen - 1, 1'b0, NO_RESULT);
      random_items++;
      if (k == pause_at) quiesce(0);
      else sender_gap(quiet ? 0 : gap_len());
    end
  endtask

  task automatic random_config();
    write_reg(CFG_VALUE_LOW,  pick_word());
    write_reg(CFG_VALUE_HIGH, pick_word());
    write_reg(CFG_MASK_LOW,   pick_mask());
    write_reg(CFG_MASK_HIGH,  pick_mask());
    write_reg(CFG_LENGTH,     pick_length());
    write_reg(CFG_MODE,       64'($urandom_range(0, 3)));
  endtask

  // ---------------------------------------------------------------------------
  // main stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    stim_row_t row;
    int rlen;
    int regions;
    int pause_at;
    bit plant;

    byte_ch.valid     <= 1'b0;
    byte_ch.data_byte <= '0;
    byte_ch.last_byte <= 1'b0;
    cfg_write         <= 1'b0;
    cfg_index         <= '0;
    cfg_data          <= '0;
    clear_scan();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table
    foreach (DIRECTED[r]) begin
      row = DIRECTED[r];
      if (row.kind == ROW_WRITE) begin
        quiesce(SETTLE_CYCLES);
        write_reg(row.reg_idx, row.reg_val);
      end else begin
        send_byte(row.data, row.last, row.kind == ROW_BYTE_KNOWN, row.want);
        sender_gap(gap_len());
      end
    end

    // stack overflow: every byte matches, forty hits into a 32-deep stack
    quiesce(SETTLE_CYCLES);
    write_reg(CFG_MASK_LOW, 64'h0);
    write_reg(CFG_LENGTH, 64'd1);
    write_reg(CFG_MODE, 64'(MODE_ALL_BWD));
    run_region(40, 1'b0, -1);

    // backpressure: receiver holds off while every byte gives a result,
    // the single result register fills and the byte input must stall
    quiesce(SETTLE_CYCLES);
    write_reg(CFG_MODE, 64'(MODE_ALL_FWD));
    hold_req = 1'b1;
    quiet = 1'b1;
    run_region(24, 1'b0, -1);
    quiet = 1'b0;

    // random phases: new settings, then a few regions, most with planted matches
    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      quiesce(SETTLE_CYCLES);
      random_config();
      quiet = ($urandom_range(0, 3) == 0);
      regions = $urandom_range(1, 3);
      repeat (regions) begin
        plant = ($urandom_range(0, 3) != 0);
        rlen = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 45)
                                           : $urandom_range(1, 10);
        if (plant) rlen += pattern_span();
        // now and then the sender waits mid-region until the block is drained
        pause_at = (rlen > 1 && $urandom_range(0, 4) == 0) ? $urandom_range(0, rlen - 2)
                                                           : -1;
        run_region(rlen, plant, pause_at);
      end
    end

    quiesce(END_CYCLES);
    if (errors == 0) begin
      $display("[masked_byte_pattern_scanner] OK");
    end else begin
      $display("[masked_byte_pattern_scanner] ERROR");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // result receiver: random stalls, long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin : receiver
    int n;
    result_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        result_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        n = quiet ? 0 : gap_len();
        if (n == 0) begin
          result_ch.ready <= 1'b1;
          @(posedge clk);
        end else begin
          result_ch.ready <= 1'b0;
          repeat (n) @(posedge clk);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result checking against the oldest owed result
  // ---------------------------------------------------------------------------
  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : result_check
    scan_result_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t ns: unexpected result transfer, expected none, actual %0h/%0h/%0h/%0h",
                 $time, result_ch.match_found, result_ch.match_offset,
                 result_ch.scan_done, result_ch.stack_overflow);
        errors++;
      end else begin
        want = expected_results.pop_front();
        check_field("match_found",    32'(want.found), 32'(result_ch.match_found));
        check_field("match_offset",   want.offset,     result_ch.match_offset);
        check_field("scan_done",      32'(want.done),  32'(result_ch.scan_done));
        check_field("stack_overflow", 32'(want.ovf),   32'(result_ch.stack_overflow));
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[masked_byte_pattern_scanner] ERROR");
      $finish;
    end
  end

endmodule

`default_nettype wire
